/* design/uvs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types, constants and arithmetic helpers of the UV sphere vertex
// generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int CountW  = 9;
  localparam int RadW    = 16;
  localparam int CoordW  = 24;
  localparam int VertW   = 17;
  localparam int QuoW    = 17;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 24;
  localparam int ProdW   = 32;
  localparam int TermW   = 18;
  localparam int MagW    = 16;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  localparam logic signed [CoordW-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [CoordW-1:0] COORD_MIN = -24'sh800000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STACK_COUNT = 3'd0,
    REG_SLICE_COUNT = 3'd1,
    REG_RADIUS      = 3'd2,
    REG_CENTER_X    = 3'd3,
    REG_CENTER_Y    = 3'd4,
    REG_CENTER_Z    = 3'd5
  } uvs_reg_e;

  // per-item data that rides alongside the arithmetic
  typedef struct packed {
    logic             oor;
    logic [VertW-1:0] vn;
    logic [VertW-1:0] bn;
    logic             upper;
    logic             lower;
  } uvs_side_t;

  // table magnitudes and quadrant signs: sinE, cosE, sinA, cosA
  typedef struct packed {
    logic [3:0]      neg;
    logic [MagW-1:0] sin_e;
    logic [MagW-1:0] cos_e;
    logic [MagW-1:0] sin_a;
    logic [MagW-1:0] cos_a;
  } uvs_trig_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic [VertW-1:0]         vertex_number;
    logic [VertW-1:0]         below_number;
    logic                     upper_tri_valid;
    logic                     lower_tri_valid;
    logic                     out_of_range;
  } uvs_result_t;

  // (a*b) >> 62, elaboration use only
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[125:62];
  endfunction

  // divide by 2^14, round to nearest, ties away from zero
  function automatic logic signed [TermW-1:0] round_q14(input logic signed [ProdW-1:0] v);
    logic [ProdW:0] mag;
    logic [ProdW:0] r;
    mag = v[ProdW-1] ? (ProdW+1)'(-(ProdW+1)'(v)) : (ProdW+1)'(v);
    r   = (mag + (ProdW+1)'(8192)) >> 14;
    return v[ProdW-1] ? -TermW'(r) : TermW'(r);
  endfunction

endpackage

/* design/uvs_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_in_if / uvs_out_if
// Valid/ready channels for grid points and vertex results.
// ----------------------------------------------------------------------------
interface uvs_in_if;
  logic       valid;
  logic       ready;
  logic [8:0] row_index;
  logic [8:0] column_index;

  modport source (output valid, output row_index, output column_index, input ready);
  modport sink   (input valid, input row_index, input column_index, output ready);
endinterface

interface uvs_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] pos_z;
  logic [16:0]        vertex_number;
  logic [16:0]        below_number;
  logic               upper_tri_valid;
  logic               lower_tri_valid;
  logic               out_of_range;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output vertex_number, output below_number, output upper_tri_valid,
                  output lower_tri_valid, output out_of_range, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input vertex_number, input below_number, input upper_tri_valid,
                  input lower_tri_valid, input out_of_range, output ready);
endinterface

/* design/uvs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_front
// Input stage: range check, flat vertex indices and triangle flags.
// ----------------------------------------------------------------------------
module uvs_front import uvs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [CountW-1:0] row_i,
  input  logic [CountW-1:0] col_i,
  input  logic [CountW-1:0] stacks_i,
  input  logic [CountW-1:0] slices_i,
  output logic              valid_o,
  output logic [CountW-1:0] row_o,
  output logic [CountW-1:0] col_o,
  output uvs_side_t         side_o
);

  logic              valid_q;
  logic [CountW-1:0] row_q, col_q;
  uvs_side_t         side_d, side_q;
  logic [CountW+CountW:0] vn_full;

  always_comb begin
    vn_full      = (2*CountW+1)'(row_i) * (2*CountW+1)'({1'b0, slices_i} + 10'd1)
                 + (2*CountW+1)'(col_i);
    side_d.oor   = (row_i > stacks_i) || (col_i > slices_i);
    side_d.vn    = VertW'(vn_full);
    side_d.bn    = VertW'(vn_full) + VertW'(slices_i) + VertW'(1);
    side_d.upper = (row_i != '0) && (row_i < stacks_i) && (col_i < slices_i);
    side_d.lower = ({1'b0, row_i} + 10'd1 < {1'b0, stacks_i}) && (col_i < slices_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q  <= row_i;
      col_q  <= col_i;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign row_o   = row_q;
  assign col_o   = col_q;
  assign side_o  = side_q;

endmodule

/* design/uvs_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider, one quotient bit per stage, for
// (row << 16) / stacks and (col << 16) / slices side by side.
// ----------------------------------------------------------------------------
module uvs_div import uvs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [CountW-1:0] row_i,
  input  logic [CountW-1:0] col_i,
  input  uvs_side_t         side_i,
  input  logic [CountW-1:0] stacks_i,
  input  logic [CountW-1:0] slices_i,
  output logic              valid_o,
  output uvs_side_t         side_o,
  output logic [QuoW-1:0]   quo_e_o,
  output logic [QuoW-1:0]   quo_a_o
);

  logic              v_q     [QuoW];
  uvs_side_t         side_q  [QuoW];
  logic [CountW-1:0] rem_e_q [QuoW];
  logic [CountW-1:0] rem_a_q [QuoW];
  logic [QuoW-1:0]   quo_e_q [QuoW];
  logic [QuoW-1:0]   quo_a_q [QuoW];

  for (genvar s = 0; s < QuoW; s++) begin : g_step
    logic              v_in;
    uvs_side_t         side_in;
    logic [CountW-1:0] re_in, ra_in;
    logic [QuoW-1:0]   qe_in, qa_in;
    logic              be, ba;
    logic [CountW:0]   sh_e, sh_a;
    logic              ge_e, ge_a;

    if (s == 0) begin : g_first
      // in range the top dividend bits are below the divisor
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign re_in   = {1'b0, row_i[CountW-1:1]};
      assign ra_in   = {1'b0, col_i[CountW-1:1]};
      assign be      = row_i[0];
      assign ba      = col_i[0];
      assign qe_in   = '0;
      assign qa_in   = '0;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign side_in = side_q[s-1];
      assign re_in   = rem_e_q[s-1];
      assign ra_in   = rem_a_q[s-1];
      assign be      = 1'b0;
      assign ba      = 1'b0;
      assign qe_in   = quo_e_q[s-1];
      assign qa_in   = quo_a_q[s-1];
    end

    always_comb begin
      sh_e = {re_in, be};
      sh_a = {ra_in, ba};
      ge_e = sh_e >= {1'b0, stacks_i};
      ge_a = sh_a >= {1'b0, slices_i};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s]  <= side_in;
        rem_e_q[s] <= ge_e ? CountW'(sh_e - {1'b0, stacks_i}) : sh_e[CountW-1:0];
        rem_a_q[s] <= ge_a ? CountW'(sh_a - {1'b0, slices_i}) : sh_a[CountW-1:0];
        quo_e_q[s] <= {qe_in[QuoW-2:0], ge_e};
        quo_a_q[s] <= {qa_in[QuoW-2:0], ge_a};
      end
    end
  end

  assign valid_o = v_q[QuoW-1];
  assign side_o  = side_q[QuoW-1];
  assign quo_e_o = quo_e_q[QuoW-1];
  assign quo_a_o = quo_a_q[QuoW-1];

endmodule

/* design/uvs_trig.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_trig
// Turns the quotients into phases and reads sine and cosine of elevation
// and azimuth from two quarter-wave ROMs.
// ----------------------------------------------------------------------------
module uvs_trig import uvs_pkg::*; #(
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  uvs_side_t       side_i,
  input  logic [QuoW-1:0] quo_e_i,
  input  logic [QuoW-1:0] quo_a_i,
  output logic            valid_o,
  output uvs_side_t       side_o,
  output uvs_trig_t       trig_o
);

  localparam int AddrW = $clog2(SINE_TABLE_ENTRIES + 1);

  typedef logic [MagW-1:0] rom_t [SINE_TABLE_ENTRIES+1];

  // Taylor series of sin(x), x in Q2.62, rounded to Q2.14
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] x, x2, term, sum;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      x    = (HALF_PI_Q62 / SINE_TABLE_ENTRIES) * 64'(k)
           + ((HALF_PI_Q62 % SINE_TABLE_ENTRIES) * 64'(k)) / SINE_TABLE_ENTRIES;
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int m = 1; m <= 12; m++) begin
        term = mul_q62(term, x2) / 64'((2 * m) * (2 * m + 1));
        if (m % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      rom[k] = MagW'((sum + (64'd1 << 47)) >> 48);
    end
    return rom;
  endfunction

  localparam rom_t ROM_E = build_rom();
  localparam rom_t ROM_A = build_rom();

  // {negate, table address} for the sine of a phase
  function automatic logic [AddrW:0] addr_of(input logic [15:0] p);
    logic [31:0] tt;
    logic [31:0] idx;
    tt = (32'(p[13:0]) * 32'(SINE_TABLE_ENTRIES) + 32'd8192) >> 14;
    if (tt > 32'(SINE_TABLE_ENTRIES)) tt = 32'(SINE_TABLE_ENTRIES);
    idx = p[14] ? 32'(SINE_TABLE_ENTRIES) - tt : tt;
    return {p[15], AddrW'(idx)};
  endfunction

  logic [15:0]    ph_e, ph_a;
  logic [AddrW:0] a_se_d, a_ce_d, a_sa_d, a_ca_d;
  logic [AddrW:0] a_se_q, a_ce_q, a_sa_q, a_ca_q;
  logic           v1_q, v2_q;
  uvs_side_t      side1_q, side2_q;
  uvs_trig_t      trig_q;

  always_comb begin
    ph_e   = 16'(17'd16384 - (quo_e_i >> 1));
    ph_a   = quo_a_i[15:0];
    a_se_d = addr_of(ph_e);
    a_ce_d = addr_of(ph_e + 16'd16384);
    a_sa_d = addr_of(ph_a);
    a_ca_d = addr_of(ph_a + 16'd16384);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q      <= side_i;
      a_se_q       <= a_se_d;
      a_ce_q       <= a_ce_d;
      a_sa_q       <= a_sa_d;
      a_ca_q       <= a_ca_d;
      side2_q      <= side1_q;
      trig_q.neg   <= {a_se_q[AddrW], a_ce_q[AddrW], a_sa_q[AddrW], a_ca_q[AddrW]};
      trig_q.sin_e <= ROM_E[a_se_q[AddrW-1:0]];
      trig_q.cos_e <= ROM_E[a_ce_q[AddrW-1:0]];
      trig_q.sin_a <= ROM_A[a_sa_q[AddrW-1:0]];
      trig_q.cos_a <= ROM_A[a_ca_q[AddrW-1:0]];
    end
  end

  assign valid_o = v2_q;
  assign side_o  = side2_q;
  assign trig_o  = trig_q;

endmodule

/* design/uvs_pos.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pos
// Scales the unit vector by the radius, adds the center with saturation
// and holds the result register.
// ----------------------------------------------------------------------------
module uvs_pos import uvs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  uvs_side_t                side_i,
  input  uvs_trig_t                trig_i,
  input  logic [RadW-1:0]          radius_i,
  input  logic signed [CoordW-1:0] center_x_i,
  input  logic signed [CoordW-1:0] center_y_i,
  input  logic signed [CoordW-1:0] center_z_i,
  output logic                     valid_o,
  output uvs_result_t              result_o
);

  function automatic logic signed [MagW:0] apply_sign(input logic neg, input logic [MagW-1:0] m);
    return neg ? -(MagW+1)'(m) : (MagW+1)'(m);
  endfunction

  function automatic logic signed [CoordW-1:0] sat_add(input logic signed [CoordW-1:0] c,
                                                       input logic signed [TermW-1:0] t);
    logic signed [CoordW+1:0] s;
    s = (CoordW+2)'(c) + (CoordW+2)'(t);
    if (s > (CoordW+2)'(COORD_MAX)) return COORD_MAX;
    if (s < (CoordW+2)'(COORD_MIN)) return COORD_MIN;
    return CoordW'(s);
  endfunction

  logic                    v1_q, v2_q, v3_q, v4_q;
  uvs_side_t               side1_q, side2_q, side3_q;
  logic signed [ProdW-1:0] ring_p_q, z_p_q, x_p_q, y_p_q;
  logic signed [MagW:0]    cos_a1_q, sin_a1_q, cos_a2_q, sin_a2_q;
  logic signed [TermW-1:0] ring_q, z_t2_q, z_t3_q;
  logic signed [MagW:0]    rad_s;
  uvs_result_t             res_d, res_q;

  assign rad_s = {1'b0, radius_i};

  always_comb begin
    res_d = '0;
    if (side3_q.oor) begin
      res_d.out_of_range = 1'b1;
    end else begin
      res_d.pos_x           = sat_add(center_x_i, round_q14(x_p_q));
      res_d.pos_y           = sat_add(center_y_i, round_q14(y_p_q));
      res_d.pos_z           = sat_add(center_z_i, z_t3_q);
      res_d.vertex_number   = side3_q.vn;
      res_d.below_number    = side3_q.bn;
      res_d.upper_tri_valid = side3_q.upper;
      res_d.lower_tri_valid = side3_q.lower;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // radius times elevation terms
      side1_q  <= side_i;
      ring_p_q <= ProdW'(rad_s * apply_sign(trig_i.neg[2], trig_i.cos_e));
      z_p_q    <= ProdW'(rad_s * apply_sign(trig_i.neg[3], trig_i.sin_e));
      cos_a1_q <= apply_sign(trig_i.neg[0], trig_i.cos_a);
      sin_a1_q <= apply_sign(trig_i.neg[1], trig_i.sin_a);
      // ring radius
      side2_q  <= side1_q;
      ring_q   <= round_q14(ring_p_q);
      z_t2_q   <= round_q14(z_p_q);
      cos_a2_q <= cos_a1_q;
      sin_a2_q <= sin_a1_q;
      // ring times azimuth terms
      side3_q  <= side2_q;
      x_p_q    <= ProdW'(ring_q * cos_a2_q);
      y_p_q    <= ProdW'(ring_q * sin_a2_q);
      z_t3_q   <= z_t2_q;
      // result register
      res_q    <= res_d;
    end
  end

  assign valid_o  = v4_q;
  assign result_o = res_q;

endmodule

/* design/uv_sphere_vertex_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Streams UV sphere grid points into vertex positions, flat vertex indices
// and triangle flags.
// ----------------------------------------------------------------------------
// Accepts one grid point per clock while the output side keeps up. Each
// point passes one input register, 17 divider stages (one quotient bit
// each, turning row and column into turn phases), an address stage and a
// registered ROM read for sine and cosine, then three multiply and round
// stages and the saturating result register. A stall on the output
// freezes the whole pipeline; no item is dropped or repeated.
// Configuration must only change while the pipeline is empty.
module uv_sphere_vertex_generator import uvs_pkg::*; #(
  parameter int MAX_DIVISIONS      = 256,
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  uvs_in_if.sink             item_i,
  uvs_out_if.source          result_o
);

  logic [CountW-1:0]        stack_q, slice_q;
  logic [RadW-1:0]          radius_q;
  logic signed [CoordW-1:0] cx_q, cy_q, cz_q;
  logic [CountW-1:0]        stacks, slices;
  logic [RadW-1:0]          radius;
  logic                     en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_q  <= CountW'(16);
      slice_q  <= CountW'(32);
      radius_q <= RadW'(256);
      cx_q     <= '0;
      cy_q     <= '0;
      cz_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STACK_COUNT: stack_q  <= cfg_data_i[CountW-1:0];
        REG_SLICE_COUNT: slice_q  <= cfg_data_i[CountW-1:0];
        REG_RADIUS:      radius_q <= cfg_data_i[RadW-1:0];
        REG_CENTER_X:    cx_q     <= cfg_data_i;
        REG_CENTER_Y:    cy_q     <= cfg_data_i;
        REG_CENTER_Z:    cz_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    stacks = (stack_q < CountW'(2)) ? CountW'(2) : stack_q;
    if (int'(stacks) > MAX_DIVISIONS) stacks = CountW'(MAX_DIVISIONS);
    slices = (slice_q < CountW'(3)) ? CountW'(3) : slice_q;
    if (int'(slices) > MAX_DIVISIONS) slices = CountW'(MAX_DIVISIONS);
    radius = (radius_q < RadW'(3)) ? RadW'(3) : radius_q;
  end

  logic              f_valid, d_valid, t_valid, p_valid;
  logic [CountW-1:0] f_row, f_col;
  uvs_side_t         f_side, d_side, t_side;
  logic [QuoW-1:0]   quo_e, quo_a;
  uvs_trig_t         trig;
  uvs_result_t       res;

  // pipeline advances unless a finished result is waiting
  assign en           = !p_valid || result_o.ready;
  assign item_i.ready = en;

  uvs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (item_i.valid),
    .row_i    (item_i.row_index),
    .col_i    (item_i.column_index),
    .stacks_i (stacks),
    .slices_i (slices),
    .valid_o  (f_valid),
    .row_o    (f_row),
    .col_o    (f_col),
    .side_o   (f_side)
  );

  uvs_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (f_valid),
    .row_i    (f_row),
    .col_i    (f_col),
    .side_i   (f_side),
    .stacks_i (stacks),
    .slices_i (slices),
    .valid_o  (d_valid),
    .side_o   (d_side),
    .quo_e_o  (quo_e),
    .quo_a_o  (quo_a)
  );

  uvs_trig #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
  ) u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .side_i  (d_side),
    .quo_e_i (quo_e),
    .quo_a_i (quo_a),
    .valid_o (t_valid),
    .side_o  (t_side),
    .trig_o  (trig)
  );

  uvs_pos u_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (t_valid),
    .side_i     (t_side),
    .trig_i     (trig),
    .radius_i   (radius),
    .center_x_i (cx_q),
    .center_y_i (cy_q),
    .center_z_i (cz_q),
    .valid_o    (p_valid),
    .result_o   (res)
  );

  assign result_o.valid           = p_valid;
  assign result_o.pos_x           = res.pos_x;
  assign result_o.pos_y           = res.pos_y;
  assign result_o.pos_z           = res.pos_z;
  assign result_o.vertex_number   = res.vertex_number;
  assign result_o.below_number    = res.below_number;
  assign result_o.upper_tri_valid = res.upper_tri_valid;
  assign result_o.lower_tri_valid = res.lower_tri_valid;
  assign result_o.out_of_range    = res.out_of_range;

`ifndef SYNTHESIS
  // a waiting result blocks new transfers
  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.ready) |-> !item_i.ready)
    else $error("input accepted while result stalled");

  // out-of-range results carry nothing else
  a_oor_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.out_of_range) |->
      (result_o.vertex_number == '0 && result_o.below_number == '0 &&
       result_o.pos_x == '0 && result_o.pos_y == '0 && result_o.pos_z == '0))
    else $error("out-of-range result has nonzero fields");

  // a triangle only exists for an in-range point
  a_tri_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.upper_tri_valid || result_o.lower_tri_valid)) |->
      !result_o.out_of_range)
    else $error("triangle flagged on out-of-range point");
`endif

endmodule
